// ===== hw/rtl/timestamp_ordered_event_queue_assert.svh =====
// assertion helpers for the event queue
`ifndef TIMESTAMP_ORDERED_EVENT_QUEUE_ASSERT_SVH
`define TIMESTAMP_ORDERED_EVENT_QUEUE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TOEQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("event queue check failed");

// next-cycle implication, checked outside reset
`define TOEQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("event queue check failed");

`endif

// ===== hw/rtl/toeq_pkg.sv =====
package toeq_pkg;

   localparam int TimeWidth = 16;
   localparam int KindWidth = 2;
   localparam int OccWidth  = 5;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_PEEK   = 2'd1;
   localparam logic [1:0] OP_POP    = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_POP    = 2'd2
   } cmd_op_type;

   typedef struct packed {
      logic                 valid;
      logic [TimeWidth-1:0] stamp;
      logic [KindWidth-1:0] kind;
   } slot_type;

   typedef struct packed {
      cmd_op_type           op;
      logic [TimeWidth-1:0] stamp;
      logic [KindWidth-1:0] kind;
   } cmd_type;

   // what a cell shows its neighbors
   typedef struct packed {
      slot_type slot;
      logic     less;
   } link_type;

endpackage

// ===== hw/rtl/toeq_cell.sv =====
module toeq_cell
   import toeq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  link_type prev_link,
   input  slot_type next_slot,
   output link_type link
);

   slot_type slot_ff;
   slot_type slot_in;
   logic     less;

   // stored event is strictly earlier than the new one
   assign less = slot_ff.valid && (slot_ff.stamp < cmd.stamp);

   always_comb begin
      slot_in = slot_ff;
      unique case (cmd.op)
         CMD_INSERT: begin
            if (less) begin
               slot_in = slot_ff;
            end else if (prev_link.less) begin
               slot_in.valid = 1'b1;
               slot_in.stamp = cmd.stamp;
               slot_in.kind  = cmd.kind;
            end else begin
               slot_in = prev_link.slot;
            end
         end
         CMD_POP: begin
            slot_in = next_slot;
         end
         default: begin
            slot_in = slot_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
      end
      slot_ff.stamp <= slot_in.stamp;
      slot_ff.kind  <= slot_in.kind;
   end

   assign link.slot = slot_ff;
   assign link.less = less;

endmodule

// ===== hw/rtl/timestamp_ordered_event_queue.sv =====
// channel   | ports                                          | transfer when
// ----------+------------------------------------------------+-------------------------
// request   | start, busy, req_op, req_event_time,           | start high, busy low
//           | req_event_kind                                 |
// response  | rsp_strobe, rsp_status, rsp_head_valid,        | rsp_strobe high (one
//           | rsp_head_time, rsp_head_kind, rsp_occupancy    | cycle, no back-pressure)
//
// one operation per clock while not busy: every cell compares its own slot against the
// new time in parallel and shifts or holds in the same cycle, setting the rate
// the response appears in the cycle after the request transfer, from registers
// synchronous reset empties the queue; busy is set in reset and clears once it ends;
// the receiver cannot stall, so busy never rises during normal operation
`include "timestamp_ordered_event_queue_assert.svh"

module timestamp_ordered_event_queue
   import toeq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_op,
   input  logic [TimeWidth-1:0] req_event_time,
   input  logic [KindWidth-1:0] req_event_kind,
   output logic                 rsp_strobe,
   output logic [1:0]           rsp_status,
   output logic                 rsp_head_valid,
   output logic [TimeWidth-1:0] rsp_head_time,
   output logic [KindWidth-1:0] rsp_head_kind,
   output logic [OccWidth-1:0]  rsp_occupancy
);

   localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);

   // cell row
   link_type                 links [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]   valid_vec;
   cmd_type                  cmd;

   // control
   logic                     busy_ff;
   logic                     accept;
   logic                     full;
   logic                     empty;
   logic [CntWidth-1:0]      occ_ff;
   logic [CntWidth-1:0]      occ_in;
   logic [CntWidth+OccWidth-1:0] occ_ext;

   // response registers
   logic                     rsp_strobe_ff;
   logic [1:0]               rsp_status_ff;
   logic [1:0]               rsp_status_in;
   logic                     rsp_head_valid_ff;
   logic                     rsp_head_valid_in;
   logic [TimeWidth-1:0]     rsp_head_time_ff;
   logic [TimeWidth-1:0]     rsp_head_time_in;
   logic [KindWidth-1:0]     rsp_head_kind_ff;
   logic [KindWidth-1:0]     rsp_head_kind_in;
   logic [OccWidth-1:0]      rsp_occupancy_ff;

   assign accept = start && !busy_ff;
   assign full   = links[QUEUE_DEPTH-1].slot.valid;
   assign empty  = !links[0].slot.valid;

   // broadcast command, gated so a dropped insert or an empty pop changes nothing
   always_comb begin
      cmd.op    = CMD_HOLD;
      cmd.stamp = req_event_time;
      cmd.kind  = req_event_kind;
      if (accept) begin
         if (req_op == OP_INSERT && !full) begin
            cmd.op = CMD_INSERT;
         end else if (req_op == OP_POP && !empty) begin
            cmd.op = CMD_POP;
         end
      end
   end

   // row of cells, head at index 0
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      link_type prev_link;
      slot_type next_slot;

      if (i == 0) begin : g_head
         // nothing ahead of the head, so an insert may always land here
         assign prev_link.slot = '0;
         assign prev_link.less = 1'b1;
      end else begin : g_mid
         assign prev_link = links[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         // pop pulls an empty slot into the tail
         assign next_slot = '0;
      end else begin : g_body
         assign next_slot = links[i+1].slot;
      end

      toeq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .prev_link (prev_link),
         .next_slot (next_slot),
         .link      (links[i])
      );

      assign valid_vec[i] = links[i].slot.valid;
   end

   // occupancy count
   always_comb begin
      occ_in = occ_ff;
      case (cmd.op)
         CMD_INSERT: occ_in = occ_ff + CntWidth'(1);
         CMD_POP:    occ_in = occ_ff - CntWidth'(1);
         default:    occ_in = occ_ff;
      endcase
   end

   // result field keeps only the low bits of the count
   assign occ_ext = {{OccWidth{1'b0}}, occ_in};

   // response fields
   always_comb begin
      rsp_status_in     = ST_OK;
      rsp_head_valid_in = 1'b1;
      rsp_head_time_in  = links[0].slot.stamp;
      rsp_head_kind_in  = links[0].slot.kind;
      if (req_op == OP_INSERT) begin
         if (full) begin
            rsp_status_in = ST_FULL;
         end else if (!links[0].less) begin
            // new event becomes the head
            rsp_head_time_in = req_event_time;
            rsp_head_kind_in = req_event_kind;
         end
      end else if (empty) begin
         rsp_status_in     = ST_EMPTY;
         rsp_head_valid_in = 1'b0;
         rsp_head_time_in  = '0;
         rsp_head_kind_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         occ_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         occ_ff        <= occ_in;
         rsp_strobe_ff <= accept;
      end
      if (accept) begin
         rsp_status_ff     <= rsp_status_in;
         rsp_head_valid_ff <= rsp_head_valid_in;
         rsp_head_time_ff  <= rsp_head_time_in;
         rsp_head_kind_ff  <= rsp_head_kind_in;
         rsp_occupancy_ff  <= occ_ext[OccWidth-1:0];
      end
   end

   assign busy           = busy_ff;
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_head_valid = rsp_head_valid_ff;
   assign rsp_head_time  = rsp_head_time_ff;
   assign rsp_head_kind  = rsp_head_kind_ff;
   assign rsp_occupancy  = rsp_occupancy_ff;

   // valid slots always form a prefix of the row
   `TOEQ_ASSERT_NOW(a_valid_prefix, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0)
   // counter tracks the valid bits
   `TOEQ_ASSERT_NOW(a_occ_matches, 1'b1, occ_ff == CntWidth'($countones(valid_vec)))
   // every transfer yields exactly one response next cycle
   `TOEQ_ASSERT_NEXT(a_rsp_follows, accept, rsp_strobe)
   // full status only when every slot is taken
   `TOEQ_ASSERT_NOW(a_full_status, rsp_strobe && rsp_status == ST_FULL,
      occ_ff == CntWidth'(QUEUE_DEPTH))

endmodule
